// ===== rtl/watchdog_window_chooser_defines.svh =====
// assertion macros for the watchdog window chooser
// no dependencies; included by the top level, the only module that carries checks
`ifndef WATCHDOG_WINDOW_CHOOSER_DEFINES_SVH
`define WATCHDOG_WINDOW_CHOOSER_DEFINES_SVH

`ifndef SYNTH
// check on rising i_clk, switched off while dis_expr holds
`define WWC_ASSERT_DIS(label, dis_expr, prop) \
    label: assert property (@(posedge i_clk) disable iff (dis_expr) prop) \
        else $error("wwc check failed");
// check on rising i_clk, switched off during reset
`define WWC_ASSERT(label, prop) \
    `WWC_ASSERT_DIS(label, !i_rst_n, prop)
`else
`define WWC_ASSERT_DIS(label, dis_expr, prop)
`define WWC_ASSERT(label, prop)
`endif

`endif

// ===== rtl/wwc_pkg.sv =====
// shared types, constants and tables of the watchdog window chooser
// no dependencies; used by every module of the block
package wwc_pkg;

    localparam int MS_W    = 32;
    localparam int CLK_W   = 32;
    localparam int REQ_W   = 42;   // ms * 1000 fits here
    localparam int NUM_W   = 49;   // 1e6 << 29 fits here
    localparam int CNT_W   = 6;    // holds NUM_W
    localparam int SLACK_W = 50;   // full slack before saturation
    localparam int OUT_SLACK_W = 43;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_CLOCK_HZ = 2'd0;
    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = 32'd50000000;
    localparam logic [NUM_W-1:0]  USEC_PER_S = 49'd1000000;
    localparam logic [9:0]        USEC_PER_MS = 10'd1000;
    localparam logic [3:0]        RANGE_LAST = 4'd9;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_NOFIT   = 2'd2;

    typedef struct packed {
        logic [MS_W-1:0] window_min_ms;
        logic [MS_W-1:0] window_max_ms;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [1:0]             period_index;
        logic [2:0]             divider_index;
        logic [3:0]             range_index;
        logic [OUT_SLACK_W-1:0] slack_us;
    } t_resp;

    // program steps of the sequencer
    typedef enum logic [2:0] {
        ST_WAIT, ST_CHECK, ST_DIV_GO, ST_DIV_WAIT,
        ST_EVAL, ST_NEXT, ST_FINISH, ST_RETURN
    } t_step;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_DIV_GO, OP_EVAL, OP_NEXT, OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_NO_REQ, C_BAD, C_DIV_BUSY,
        C_K_MORE, C_PAIR_MORE, C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic div_go;
        logic eval;
        logic next_pair;
    } t_dp_ctl;

    typedef struct packed {
        logic bad;
        logic div_busy;
        logic k_last;
        logic pair_last;
    } t_dp_stat;

    // log2 of count period plus log2 of divider
    function automatic logic [4:0] pair_shift(input logic [1:0] pi, input logic [2:0] di);
        logic [4:0] ps;
        logic [4:0] ds;
        case (pi)
            2'd0:    ps = 5'd8;
            2'd1:    ps = 5'd12;
            2'd2:    ps = 5'd14;
            default: ps = 5'd16;
        endcase
        case (di)
            3'd0:    ds = 5'd2;
            3'd1:    ds = 5'd6;
            3'd2:    ds = 5'd7;
            3'd3:    ds = 5'd8;
            3'd4:    ds = 5'd9;
            3'd5:    ds = 5'd10;
            3'd6:    ds = 5'd11;
            default: ds = 5'd13;
        endcase
        return ps + ds;
    endfunction

    // range bounds in quarters: 25 percent steps
    function automatic logic [2:0] range_lo_q(input logic [3:0] k);
        case (k)
            4'd4, 4'd5, 4'd6: return 3'd1;
            4'd7, 4'd8:       return 3'd2;
            4'd9:             return 3'd3;
            default:          return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] range_hi_q(input logic [3:0] k);
        case (k)
            4'd0:             return 3'd1;
            4'd1, 4'd4:       return 3'd2;
            4'd2, 4'd5, 4'd7: return 3'd3;
            default:          return 3'd4;
        endcase
    endfunction

    // floor(t * q / 4)
    function automatic logic [NUM_W-1:0] quarters(input logic [NUM_W-1:0] t,
                                                  input logic [2:0] q);
        logic [NUM_W+1:0] te;
        logic [NUM_W+1:0] prod;
        te = {2'b00, t};
        case (q)
            3'd1:    prod = te;
            3'd2:    prod = te << 1;
            3'd3:    prod = te + (te << 1);
            3'd4:    prod = te << 2;
            default: prod = '0;
        endcase
        return prod[NUM_W+1:2];
    endfunction

endpackage

// ===== rtl/wwc_ucode_rom.sv =====
// control store of the window search program
// depends on wwc_pkg for step, op and condition codes
module wwc_ucode_rom (
    input  wwc_pkg::t_step  i_pc,
    output wwc_pkg::t_uword o_uword
);

    always_comb begin
        unique case (i_pc)
            wwc_pkg::ST_WAIT:     o_uword = '{wwc_pkg::OP_LOAD,   wwc_pkg::C_NO_REQ,
                                              wwc_pkg::ST_WAIT};
            wwc_pkg::ST_CHECK:    o_uword = '{wwc_pkg::OP_NONE,   wwc_pkg::C_BAD,
                                              wwc_pkg::ST_FINISH};
            wwc_pkg::ST_DIV_GO:   o_uword = '{wwc_pkg::OP_DIV_GO, wwc_pkg::C_NEVER,
                                              wwc_pkg::ST_WAIT};
            wwc_pkg::ST_DIV_WAIT: o_uword = '{wwc_pkg::OP_NONE,   wwc_pkg::C_DIV_BUSY,
                                              wwc_pkg::ST_DIV_WAIT};
            wwc_pkg::ST_EVAL:     o_uword = '{wwc_pkg::OP_EVAL,   wwc_pkg::C_K_MORE,
                                              wwc_pkg::ST_EVAL};
            wwc_pkg::ST_NEXT:     o_uword = '{wwc_pkg::OP_NEXT,   wwc_pkg::C_PAIR_MORE,
                                              wwc_pkg::ST_DIV_GO};
            wwc_pkg::ST_FINISH:   o_uword = '{wwc_pkg::OP_FINISH, wwc_pkg::C_OUT_FULL,
                                              wwc_pkg::ST_FINISH};
            wwc_pkg::ST_RETURN:   o_uword = '{wwc_pkg::OP_NONE,   wwc_pkg::C_ALWAYS,
                                              wwc_pkg::ST_WAIT};
            default:              o_uword = '{wwc_pkg::OP_NONE,   wwc_pkg::C_ALWAYS,
                                              wwc_pkg::ST_WAIT};
        endcase
    end

endmodule

// ===== rtl/wwc_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on wwc_pkg for widths
module wwc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wwc_pkg::NUM_W-1:0]     i_num,
    input  logic [wwc_pkg::CLK_W-1:0]     i_den,
    output logic                          o_busy,
    output logic [wwc_pkg::NUM_W-1:0]     o_quot
);

    logic                        r_busy, n_busy;
    logic [wwc_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [wwc_pkg::NUM_W-1:0]   r_quo, n_quo;
    logic [wwc_pkg::CLK_W-1:0]   r_rem, n_rem;
    logic [wwc_pkg::CLK_W-1:0]   r_den, n_den;
    logic [wwc_pkg::CLK_W:0]     w_trial;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[wwc_pkg::NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = wwc_pkg::CNT_W'(wwc_pkg::NUM_W);
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_quo  = {r_quo[wwc_pkg::NUM_W-2:0], w_ge};
            n_rem  = w_ge ? wwc_pkg::CLK_W'(w_trial - {1'b0, r_den})
                          : w_trial[wwc_pkg::CLK_W-1:0];
            n_cnt  = r_cnt - 1'b1;
            n_busy = r_cnt != wwc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

// ===== rtl/wwc_datapath.sv =====
// search datapath: request registers, loop indices, window test, best keeper
// depends on wwc_pkg and wwc_divider
module wwc_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wwc_pkg::t_dp_ctl           i_ctl,
    input  wwc_pkg::t_req              i_req,
    input  logic [wwc_pkg::CLK_W-1:0]  i_den,
    output wwc_pkg::t_dp_stat          o_stat,
    output wwc_pkg::t_resp             o_resp
);

    logic [wwc_pkg::REQ_W-1:0]   r_req_min, r_req_max;
    logic                        r_bad;
    logic [3:0]                  r_k;
    logic [4:0]                  r_pair;
    logic                        r_found;
    logic [wwc_pkg::SLACK_W-1:0] r_best;
    logic [4:0]                  r_best_pair;
    logic [3:0]                  r_best_k;

    logic                        w_div_busy;
    logic [wwc_pkg::NUM_W-1:0]   w_quot;
    logic [wwc_pkg::NUM_W-1:0]   w_num;
    logic [wwc_pkg::NUM_W-1:0]   w_amin, w_amax, w_rmin, w_rmax;
    logic [wwc_pkg::SLACK_W-1:0] w_slack;
    logic                        w_cover, w_better;

    assign w_num = wwc_pkg::USEC_PER_S << wwc_pkg::pair_shift(r_pair[4:3], r_pair[2:0]);

    wwc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_go),
        .i_num   (w_num),
        .i_den   (i_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // window of the current range entry against the request
    assign w_amin   = wwc_pkg::quarters(w_quot, wwc_pkg::range_lo_q(r_k));
    assign w_amax   = wwc_pkg::quarters(w_quot, wwc_pkg::range_hi_q(r_k));
    assign w_rmin   = wwc_pkg::NUM_W'(r_req_min);
    assign w_rmax   = wwc_pkg::NUM_W'(r_req_max);
    assign w_cover  = (w_amin <= w_rmin) && (w_amax >= w_rmax);
    assign w_slack  = wwc_pkg::SLACK_W'(w_rmin - w_amin) + wwc_pkg::SLACK_W'(w_amax - w_rmax);
    assign w_better = w_cover && (!r_found || (w_slack < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_pair  <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.load) begin
            r_k     <= '0;
            r_pair  <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_ctl.eval) begin
                r_k <= (r_k == wwc_pkg::RANGE_LAST) ? 4'd0 : r_k + 4'd1;
                if (w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctl.next_pair) begin
                r_pair <= r_pair + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req_min <= wwc_pkg::REQ_W'(i_req.window_min_ms) *
                         wwc_pkg::REQ_W'(wwc_pkg::USEC_PER_MS);
            r_req_max <= wwc_pkg::REQ_W'(i_req.window_max_ms) *
                         wwc_pkg::REQ_W'(wwc_pkg::USEC_PER_MS);
            r_bad     <= (i_req.window_max_ms == '0) ||
                         (i_req.window_min_ms > i_req.window_max_ms);
        end
        if (i_ctl.eval && w_better) begin
            r_best      <= w_slack;
            r_best_pair <= r_pair;
            r_best_k    <= r_k;
        end
    end

    assign o_stat.bad       = r_bad;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.k_last    = r_k == wwc_pkg::RANGE_LAST;
    assign o_stat.pair_last = &r_pair;

    always_comb begin
        o_resp = '0;
        if (r_bad) begin
            o_resp.status = wwc_pkg::STATUS_INVALID;
        end else if (!r_found) begin
            o_resp.status = wwc_pkg::STATUS_NOFIT;
        end else begin
            o_resp.status        = wwc_pkg::STATUS_OK;
            o_resp.period_index  = r_best_pair[4:3];
            o_resp.divider_index = r_best_pair[2:0];
            o_resp.range_index   = r_best_k;
            o_resp.slack_us      = (|r_best[wwc_pkg::SLACK_W-1:wwc_pkg::OUT_SLACK_W])
                                   ? '1 : r_best[wwc_pkg::OUT_SLACK_W-1:0];
        end
    end

endmodule

// ===== rtl/watchdog_window_chooser.sv =====
// watchdog window chooser top level: sequencer, clock register, result register
// depends on wwc_pkg, wwc_ucode_rom, wwc_datapath and the assertion macro header
//
// usage:
// - request channel (i_in_valid / o_in_stall / i_in_req) carries the wanted
//   refresh window in ms; result channel (o_out_valid / i_out_stall /
//   o_out_resp) returns status, chosen period/divider/range indices and slack
// - clock_hz is written over the apb-style port at address 0 by the user, only
//   while idle; the block does not enforce this; a value of zero is used as one
// - a short microcode program steps through all 32 period/divider pairs;
//   for each pair the shared divider forms the period in us (one quotient
//   bit per cycle), then each of the 10 range entries is tested
// - a valid request runs through the check step, the divider and range loop for
//   each pair, and the finish step into the result register; an invalid window
//   goes from the check step straight to the finish step
// - a new request is taken only once the program has returned to the wait step;
//   the last result may still sit in the result register when the next one is taken
// - a stalled result holds the program at its finish step until the result
//   register frees up
// - reset clears the sequencer, result valid and sets clock_hz to 50 MHz
`include "watchdog_window_chooser_defines.svh"

module watchdog_window_chooser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  wwc_pkg::t_req                 i_in_req,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output wwc_pkg::t_resp                o_out_resp,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wwc_pkg::ADDR_W-1:0]    paddr,
    input  logic [wwc_pkg::DATA_W-1:0]    pwdata,
    output logic [wwc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    wwc_pkg::t_step     r_pc, n_pc;
    wwc_pkg::t_uword    w_uw;
    wwc_pkg::t_dp_ctl   w_ctl;
    wwc_pkg::t_dp_stat  w_stat;
    wwc_pkg::t_resp     w_resp;
    logic [wwc_pkg::CLK_W-1:0] r_clock_hz;
    logic [wwc_pkg::CLK_W-1:0] w_den;
    logic               r_out_valid;
    wwc_pkg::t_resp     r_out_resp;
    logic               w_out_full;
    logic               w_take;
    logic               w_accept;
    logic               w_finish;

    // clock rate register
    assign pready = 1'b1;
    assign prdata = (paddr == wwc_pkg::ADDR_CLOCK_HZ) ? r_clock_hz : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= wwc_pkg::CLOCK_HZ_RESET;
        end else if (psel && penable && pwrite && paddr == wwc_pkg::ADDR_CLOCK_HZ) begin
            r_clock_hz <= pwdata;
        end
    end

    // zero clock acts as a divisor of one
    assign w_den = (r_clock_hz == '0) ? wwc_pkg::CLK_W'(1) : r_clock_hz;

    // control store
    wwc_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (w_uw)
    );

    // result register is full when it holds a result nobody takes this cycle
    assign w_out_full = r_out_valid && i_out_stall;

    // next step: jump on the word's condition, else fall through
    always_comb begin
        unique case (w_uw.cond)
            wwc_pkg::C_NEVER:     w_take = 1'b0;
            wwc_pkg::C_ALWAYS:    w_take = 1'b1;
            wwc_pkg::C_NO_REQ:    w_take = !i_in_valid;
            wwc_pkg::C_BAD:       w_take = w_stat.bad;
            wwc_pkg::C_DIV_BUSY:  w_take = w_stat.div_busy;
            wwc_pkg::C_K_MORE:    w_take = !w_stat.k_last;
            wwc_pkg::C_PAIR_MORE: w_take = !w_stat.pair_last;
            wwc_pkg::C_OUT_FULL:  w_take = w_out_full;
            default:              w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.target : wwc_pkg::t_step'(r_pc + 3'd1);
    end

    // control word decode into datapath strobes
    always_comb begin
        w_ctl      = '0;
        w_accept   = 1'b0;
        w_finish   = 1'b0;
        o_in_stall = 1'b1;
        unique case (w_uw.op)
            wwc_pkg::OP_NONE:   ;
            wwc_pkg::OP_LOAD: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
                w_ctl.load = i_in_valid;
            end
            wwc_pkg::OP_DIV_GO: w_ctl.div_go    = 1'b1;
            wwc_pkg::OP_EVAL:   w_ctl.eval      = 1'b1;
            wwc_pkg::OP_NEXT:   w_ctl.next_pair = 1'b1;
            wwc_pkg::OP_FINISH: w_finish        = !w_out_full;
            default:            ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= wwc_pkg::ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    wwc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_req   (i_in_req),
        .i_den   (w_den),
        .o_stat  (w_stat),
        .o_resp  (w_resp)
    );

    // result register, parts the search from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_resp <= w_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out_resp;

    // an accepted request always moves on to the window check
    `WWC_ASSERT(a_accept_to_check, w_accept |=> (r_pc == wwc_pkg::ST_CHECK))
    // a delivered result carries a known status and range entry
    `WWC_ASSERT(a_resp_codes, o_out_valid |->
        ((o_out_resp.range_index <= wwc_pkg::RANGE_LAST) &&
         (o_out_resp.status == wwc_pkg::STATUS_OK ||
          o_out_resp.status == wwc_pkg::STATUS_INVALID ||
          o_out_resp.status == wwc_pkg::STATUS_NOFIT)))
    // range entries are only tested on a settled quotient
    `WWC_ASSERT(a_eval_after_div, (r_pc == wwc_pkg::ST_EVAL) |-> !w_stat.div_busy)

endmodule
